// ===== hdl/bcvd_pkg.sv =====
package bcvd_pkg;

   localparam int LINEAR_BITS    = 12;
   localparam int COEF_FRAC_BITS = 12;

   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;
   localparam int COEF_W   = 16;
   localparam int CSR_W    = NUM_CHAN * COEF_W;
   localparam int TDATA_W  = NUM_CHAN * CHAN_W;

   // linear value 0..1.0 inclusive
   localparam int LIN_W  = LINEAR_BITS + 1;
   localparam int PROD_W = COEF_W + LIN_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int X_W    = 17;

   localparam int ENC_SHIFT = LINEAR_BITS + COEF_FRAC_BITS - 16;
   localparam logic signed [ACC_W-1:0] ACC_ONE =
      ACC_W'(longint'(1) << (LINEAR_BITS + COEF_FRAC_BITS));
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(longint'(1) << (ENC_SHIFT - 1));
   localparam logic [X_W-1:0] X_ONE = X_W'(65536);

   localparam int SEARCH_STAGES = 4;
   localparam int FRONT_STAGES  = 6;
   localparam int PIPE_DEPTH    = FRONT_STAGES + SEARCH_STAGES;

   localparam logic [COEF_W-1:0] COEF_UNIT = COEF_W'(1 << COEF_FRAC_BITS);

   typedef enum logic [2:0] {
      CSR_PLANE_NORMAL = 3'd0,
      CSR_FIRST_ROW0   = 3'd1,
      CSR_FIRST_ROW1   = 3'd2,
      CSR_FIRST_ROW2   = 3'd3,
      CSR_SECOND_ROW0  = 3'd4,
      CSR_SECOND_ROW1  = 3'd5,
      CSR_SECOND_ROW2  = 3'd6
   } csr_index_type;

   typedef logic [LIN_W-1:0] lin_table_type [256];
   typedef logic [X_W-1:0]   thr_table_type [256];

   function automatic longint unsigned qmul(input longint unsigned a,
                                            input longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint unsigned pow5(input longint unsigned r);
      longint unsigned r2;
      longint unsigned r4;
      r2 = qmul(r, r);
      r4 = qmul(r2, r2);
      return qmul(r4, r);
   endfunction

   // srgb decode of half code h/2, 16 fraction bits
   function automatic longint unsigned dec_half(input longint unsigned h_arg);
      longint unsigned h;
      longint unsigned u;
      longint unsigned u2;
      longint unsigned r;
      longint unsigned t;
      longint unsigned y;
      h = (h_arg > 64'd510) ? 64'd510 : h_arg;
      if (h <= 64'd20) begin
         return (64'd13107200 * h + 64'd658920) / 64'd1317840;
      end
      u = (((64'd1000 * h + 64'd28050) << 30) + 64'd269025) / 64'd538050;
      u2 = qmul(u, u);
      r = 64'd0;
      for (int b = 30; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t <= (64'd1 << 30) && pow5(t) <= u2) begin
            r = t;
         end
      end
      y = qmul(u2, r);
      return (y + (64'd1 << 13)) >> 14;
   endfunction

   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      longint unsigned d;
      for (int v = 0; v < 256; v++) begin
         d = dec_half(64'(2 * v));
         tbl[v] = LIN_W'((((d << 1) >> (16 - LINEAR_BITS)) + 64'd1) >> 1);
      end
      return tbl;
   endfunction

   // threshold for output code k is the decode of code k - 1/2
   function automatic thr_table_type build_thr_table();
      thr_table_type tbl;
      tbl[0] = '0;
      for (int k = 1; k < 256; k++) begin
         tbl[k] = X_W'(dec_half(64'(2 * k - 1)));
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();
   localparam thr_table_type THR_TABLE = build_thr_table();

   function automatic logic signed [COEF_W-1:0] coef_of(input logic [CSR_W-1:0] word,
                                                        input int idx);
      return signed'(word[COEF_W*idx +: COEF_W]);
   endfunction

endpackage

// ===== hdl/bcvd_search.sv =====
module bcvd_search
   import bcvd_pkg::*;
(
   input  logic              clock,
   input  logic              advance,
   input  logic [X_W-1:0]    x_value,
   output logic [CHAN_W-1:0] code
);

   logic [X_W-1:0]    x_ff [SEARCH_STAGES-1];
   logic [CHAN_W-1:0] k_ff [SEARCH_STAGES];

   // two bits of the code per stage, top bit first
   for (genvar s = 0; s < SEARCH_STAGES; s++) begin : g_stage
      localparam logic [CHAN_W-1:0] STEP_HI = CHAN_W'(1 << (CHAN_W - 1 - 2 * s));
      localparam logic [CHAN_W-1:0] STEP_LO = CHAN_W'(1 << (CHAN_W - 2 - 2 * s));
      logic [X_W-1:0]    x_src;
      logic [CHAN_W-1:0] k_src;
      logic [CHAN_W-1:0] k_mid;
      logic [CHAN_W-1:0] k_in;

      if (s == 0) begin : g_first
         assign x_src = x_value;
         assign k_src = '0;
      end else begin : g_next
         assign x_src = x_ff[s-1];
         assign k_src = k_ff[s-1];
      end

      always_comb begin
         k_mid = k_src | STEP_HI;
         if (THR_TABLE[k_mid] > x_src) begin
            k_mid = k_src;
         end
         k_in = k_mid | STEP_LO;
         if (THR_TABLE[k_in] > x_src) begin
            k_in = k_mid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            k_ff[s] <= k_in;
         end
      end

      if (s < SEARCH_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               x_ff[s] <= x_src;
            end
         end
      end
   end

   assign code = k_ff[SEARCH_STAGES-1];

endmodule

// ===== hdl/brettel_cvd_pixel_simulator.sv =====
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     req_tdata: red_in, green_in, blue_in
// rsp      out        rsp_tvalid/tready     rsp_tdata: red_out, green_out, blue_out
// csr      in         csr_valid/csr_ready   csr_index, csr_data (48 bits)
//
// one pixel per clock while rsp is not stalled
// stages: decode lookup, normal products, sign, matrix products, sums,
// clamp/round, then four stages of code search against the encode thresholds
// reset is synchronous; it empties the pipeline and loads the identity matrices
// a stalled rsp freezes every stage, req_tready drops only while rsp is held
module brettel_cvd_pixel_simulator
   import bcvd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // red_in, green_in, blue_in
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // red_out, green_out, blue_out
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_data
);

   logic [CSR_W-1:0] normal_ff;
   logic [CSR_W-1:0] first_ff  [NUM_CHAN];
   logic [CSR_W-1:0] second_ff [NUM_CHAN];

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  advance;

   logic [LIN_W-1:0]         lin1_ff [NUM_CHAN];
   logic [LIN_W-1:0]         lin2_ff [NUM_CHAN];
   logic [LIN_W-1:0]         lin3_ff [NUM_CHAN];
   logic signed [PROD_W-1:0] pnp_ff  [NUM_CHAN];
   logic                     first_ff3;
   logic signed [PROD_W-1:0] mp_ff   [NUM_CHAN][NUM_CHAN];
   logic signed [ACC_W-1:0]  acc_ff  [NUM_CHAN];
   logic [X_W-1:0]           x_ff    [NUM_CHAN];

   logic signed [ACC_W-1:0]  pn_sum;
   logic [CSR_W-1:0]         row_sel [NUM_CHAN];
   logic [CHAN_W-1:0]        code    [NUM_CHAN];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff <= '0;
         for (int j = 0; j < NUM_CHAN; j++) begin
            first_ff[j]  <= CSR_W'(COEF_UNIT) << (COEF_W * j);
            second_ff[j] <= CSR_W'(COEF_UNIT) << (COEF_W * j);
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_NORMAL: normal_ff    <= csr_data;
            CSR_FIRST_ROW0:   first_ff[0]  <= csr_data;
            CSR_FIRST_ROW1:   first_ff[1]  <= csr_data;
            CSR_FIRST_ROW2:   first_ff[2]  <= csr_data;
            CSR_SECOND_ROW0:  second_ff[0] <= csr_data;
            CSR_SECOND_ROW1:  second_ff[1] <= csr_data;
            CSR_SECOND_ROW2:  second_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign advance    = !valid_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   assign pn_sum = ACC_W'(pnp_ff[0]) + ACC_W'(pnp_ff[1]) + ACC_W'(pnp_ff[2]);

   always_comb begin
      for (int j = 0; j < NUM_CHAN; j++) begin
         row_sel[j] = first_ff3 ? first_ff[j] : second_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_CHAN; i++) begin
            // decode lookup
            lin1_ff[i] <= LIN_TABLE[req_tdata[CHAN_W*i +: CHAN_W]];
            // plane normal products
            lin2_ff[i] <= lin1_ff[i];
            pnp_ff[i]  <= coef_of(normal_ff, i) * signed'({1'b0, lin1_ff[i]});
            lin3_ff[i] <= lin2_ff[i];
         end
         // zero product picks the first matrix
         first_ff3 <= !pn_sum[ACC_W-1];
         for (int j = 0; j < NUM_CHAN; j++) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
               mp_ff[j][i] <= coef_of(row_sel[j], i) * signed'({1'b0, lin3_ff[i]});
            end
            acc_ff[j] <= ACC_W'(mp_ff[j][0]) + ACC_W'(mp_ff[j][1]) + ACC_W'(mp_ff[j][2]);
         end
      end
   end

   // clamp to 0..1 and round to 16 fraction bits
   for (genvar j = 0; j < NUM_CHAN; j++) begin : g_chan
      logic signed [ACC_W-1:0] rnd;
      logic [X_W-1:0]          x_in;

      always_comb begin
         rnd = acc_ff[j] + ACC_HALF;
         if (acc_ff[j] <= 0) begin
            x_in = '0;
         end else if (acc_ff[j] >= ACC_ONE) begin
            x_in = X_ONE;
         end else begin
            x_in = rnd[ENC_SHIFT +: X_W];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[j] <= x_in;
         end
      end

      bcvd_search u_search (
         .clock   (clock),
         .advance (advance),
         .x_value (x_ff[j]),
         .code    (code[j])
      );

      assign rsp_tdata[CHAN_W*j +: CHAN_W] = code[j];
   end

endmodule
